[design/mdf_pkg.sv]
// Shared types, codes and constants of the message duplicate filter.
// No dependencies; used by mdf_history and message_duplicate_filter_core.
package mdf_pkg;

    localparam int MAC_W       = 48;
    localparam int ID_W        = 16;
    localparam int TYPE_W      = 16;
    localparam int VERDICT_W   = 3;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 48;
    localparam int IN_DATA_W   = 128;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;
    localparam int OUT_USER_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS  = CFG_IDX_W'(1);

    localparam logic [TYPE_W-1:0] TYPE_TOPO_RESP   = 16'h0003;
    localparam logic [TYPE_W-1:0] TYPE_LINK_RESP   = 16'h0006;
    localparam logic [TYPE_W-1:0] TYPE_SRCH_RESP   = 16'h0009;
    localparam logic [TYPE_W-1:0] TYPE_WSC         = 16'h000A;
    localparam logic [TYPE_W-1:0] TYPE_HLI_RESP    = 16'h000E;
    localparam logic [TYPE_W-1:0] TYPE_PROFILE_RSP = 16'h0010;
    localparam logic [TYPE_W-1:0] TYPE_IF_PWR_RESP = 16'h0012;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_NEW      = 3'd0,
        VERDICT_OWN      = 3'd1,
        VERDICT_DUP      = 3'd2,
        VERDICT_BYPASS   = 3'd3,
        VERDICT_WSC_PASS = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [ID_W-1:0]   msg_id;
        logic [TYPE_W-1:0] msg_type;
    } t_entry;

    function automatic logic is_response_type(input logic [TYPE_W-1:0] code);
        return code == TYPE_TOPO_RESP   || code == TYPE_LINK_RESP ||
               code == TYPE_SRCH_RESP   || code == TYPE_WSC       ||
               code == TYPE_HLI_RESP    || code == TYPE_PROFILE_RSP ||
               code == TYPE_IF_PWR_RESP;
    endfunction

endpackage

[design/mdf_history.sv]
// History store of (mac, id, type) entries, one write and one registered read port.
// Depends on mdf_pkg for the entry type.
module mdf_history
    import mdf_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_entry,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_entry
);

    t_entry r_mem [ENTRIES];
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

[design/message_duplicate_filter_core.sv]
// Duplicate filter for control messages with a FIFO history of recent messages.
// Bypass or own mac decide in the check state; else the scan compares entries until a hit or the end.
// Throughput: the next transfer is taken once the result loads into the output register;
// a result stalled at the output holds the block. Scan compares one entry per cycle.
// Synchronous active-low reset clears the history count, pointer, config and output.
// Depends on mdf_pkg and mdf_history.
module message_duplicate_filter_core
    import mdf_pkg::*;
#(
    parameter int HISTORY_ENTRIES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // src_mac[47:0], tlv_mac[95:48], msg_id[111:96], msg_type[127:112]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // relayed[0], tlv_mac_present[1]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // verdict[2:0], zero[7:3]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // drop[0]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    localparam int IDX_W = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;
    localparam int CNT_W = $clog2(HISTORY_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(HISTORY_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(HISTORY_ENTRIES);

    t_state                r_state, n_state;
    logic [MAC_W-1:0]      r_own_mac, n_own_mac;
    logic                  r_bypass, n_bypass;
    t_entry                r_key, n_key;
    logic [IDX_W-1:0]      r_slot, n_slot;
    logic [IDX_W-1:0]      r_oldest, n_oldest;
    logic [CNT_W-1:0]      r_rd_cnt, n_rd_cnt;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic                  r_cmp_valid, n_cmp_valid;
    t_verdict              r_verdict, n_verdict;
    logic                  r_out_valid, n_out_valid;
    t_verdict              r_out_verdict, n_out_verdict;
    logic                  r_out_drop, n_out_drop;

    logic                  in_xfer;
    logic                  out_free;
    logic                  issue;
    logic                  hit;
    logic                  scan_done;
    logic                  bypass_hit;
    logic                  own_hit;
    logic                  hist_wr_en;
    t_entry                rd_entry;
    logic [MAC_W-1:0]      eff_mac;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign eff_mac    = (s_axis_tuser[0] && s_axis_tuser[1]) ? s_axis_tdata[95:48]
                                                             : s_axis_tdata[47:0];
    assign bypass_hit = r_bypass && is_response_type(r_key.msg_type);
    assign own_hit    = (r_key.mac == r_own_mac);
    assign issue      = (r_state == ST_SCAN) && (r_rd_cnt != r_fill);
    assign hit        = (r_state == ST_SCAN) && r_cmp_valid && (rd_entry == r_key);
    // last compare missed, or nothing to compare
    assign scan_done  = (r_state == ST_SCAN) && !hit && !issue &&
                        (r_cmp_valid || (r_fill == '0));
    assign hist_wr_en = scan_done;

    mdf_history #(
        .ENTRIES (HISTORY_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_history (
        .i_clk      (i_clk),
        .i_wr_en    (hist_wr_en),
        .i_wr_addr  (r_slot),
        .i_wr_entry (r_key),
        .i_rd_en    (issue),
        .i_rd_addr  (r_slot),
        .o_rd_entry (rd_entry)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (bypass_hit || own_hit) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit || scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_own_mac     = r_own_mac;
        n_bypass      = r_bypass;
        n_key         = r_key;
        n_slot        = r_slot;
        n_oldest      = r_oldest;
        n_rd_cnt      = r_rd_cnt;
        n_fill        = r_fill;
        n_cmp_valid   = 1'b0;
        n_verdict     = r_verdict;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_verdict = r_out_verdict;
        n_out_drop    = r_out_drop;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OWN_MAC: n_own_mac = i_cfg_data[MAC_W-1:0];
                CFG_BYPASS:  n_bypass  = i_cfg_data[0];
                default:     ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_key.mac      = eff_mac;
                    n_key.msg_id   = s_axis_tdata[111:96];
                    n_key.msg_type = s_axis_tdata[127:112];
                end
            end
            ST_CHECK: begin
                n_slot   = r_oldest;
                n_rd_cnt = '0;
                if (bypass_hit) begin
                    n_verdict = VERDICT_BYPASS;
                end else if (own_hit) begin
                    n_verdict = VERDICT_OWN;
                end
            end
            ST_SCAN: begin
                n_cmp_valid = issue;
                if (issue) begin
                    n_rd_cnt = r_rd_cnt + CNT_W'(1);
                    n_slot   = (r_slot == LAST_SLOT) ? '0 : r_slot + IDX_W'(1);
                end
                if (hit) begin
                    n_verdict = (r_key.msg_type == TYPE_WSC) ? VERDICT_WSC_PASS
                                                             : VERDICT_DUP;
                end else if (scan_done) begin
                    n_verdict = VERDICT_NEW;
                    if (r_fill != FULL_CNT) begin
                        n_fill = r_fill + CNT_W'(1);
                    end else begin
                        n_oldest = (r_oldest == LAST_SLOT) ? '0 : r_oldest + IDX_W'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_verdict;
                    n_out_drop    = (r_verdict == VERDICT_OWN) || (r_verdict == VERDICT_DUP);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_own_mac   <= '0;
            r_bypass    <= 1'b0;
            r_oldest    <= '0;
            r_fill      <= '0;
            r_rd_cnt    <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_own_mac   <= n_own_mac;
            r_bypass    <= n_bypass;
            r_oldest    <= n_oldest;
            r_fill      <= n_fill;
            r_rd_cnt    <= n_rd_cnt;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_slot        <= n_slot;
        r_verdict     <= n_verdict;
        r_out_verdict <= n_out_verdict;
        r_out_drop    <= n_out_drop;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - VERDICT_W)'(0), r_out_verdict};
    assign m_axis_tuser  = r_out_drop;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("history fill count beyond depth");

    a_oldest_until_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != FULL_CNT) |-> (r_oldest == '0))
        else $error("oldest pointer moved before history was full");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_rd_cnt <= r_fill))
        else $error("scan read past valid entries");

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_CHECK))
        else $error("accepted transfer did not start a lookup");

    a_write_only_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_wr_en |=> (r_state == ST_FINISH) && (r_verdict == VERDICT_NEW))
        else $error("history written without a new verdict");

endmodule
